### rtl/positional_list_store_defines.svh
// ----------------------------------------------------------------------------
// Positional list store assertion macros
// Concurrent assertion wrappers; empty bodies when SYNTH is defined.
// They expect clk and rst in the scope of the use.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication
`define PLS_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("positional list store assertion failed");
// Next-cycle implication
`define PLS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("positional list store assertion failed");
`else
`define PLS_ASSERT(label, ante, cons)
`define PLS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/pls_pkg.sv
// ----------------------------------------------------------------------------
// Positional list store package
// Sizes, operation and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
package pls_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 7;
  localparam int CMP_W    = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

  typedef enum logic [2:0] {
    OP_READOUT   = 3'd0,
    OP_INS_FRONT = 3'd1,
    OP_INS_BACK  = 3'd2,
    OP_INS_AT    = 3'd3,
    OP_DEL_FRONT = 3'd4,
    OP_DEL_BACK  = 3'd5,
    OP_DEL_AT    = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MODE_HOLD,
    MODE_INSERT,
    MODE_DELETE,
    MODE_ROTATE
  } mode_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    mode_t              mode;
    logic [IDX_W-1:0]   point;
    logic [IDX_W-1:0]   last_idx;
    logic signed [31:0] value;
  } ctrl_t;

endpackage

### rtl/pls_if.sv
// ----------------------------------------------------------------------------
// Positional list store channels
// Command and response stream interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pls_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic [6:0]         position;
  logic signed [31:0] value;

  modport source (output valid, output op, output position, output value, input ready);
  modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface pls_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] element;
  logic [1:0]         status;
  logic               last;

  modport source (output valid, output element, output status, output last, input ready);
  modport sink   (input valid, input element, input status, input last, output ready);
endinterface

### rtl/pls_cell.sv
// ----------------------------------------------------------------------------
// Positional list store cell
// Holds one list entry; takes from a neighbor, the new value or the front cell on insert, delete or rotate.
// ----------------------------------------------------------------------------
module pls_cell (
  input  logic                      clk,
  input  logic [pls_pkg::IDX_W-1:0] idx,
  input  pls_pkg::ctrl_t            ctrl,
  input  logic signed [31:0]        left_data,
  input  logic signed [31:0]        right_data,
  input  logic signed [31:0]        front_data,
  output logic signed [31:0]        data
);
  import pls_pkg::*;

  logic signed [31:0] data_next;

  // Pick the new entry from the broadcast command
  always_comb begin
    data_next = data;
    unique case (ctrl.mode)
      MODE_HOLD: data_next = data;
      MODE_INSERT: begin
        if (idx > ctrl.point) begin
          data_next = left_data;
        end else if (idx == ctrl.point) begin
          data_next = ctrl.value;
        end
      end
      MODE_DELETE: begin
        if (idx >= ctrl.point) begin
          data_next = right_data;
        end
      end
      MODE_ROTATE: data_next = (idx == ctrl.last_idx) ? front_data : right_data;
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

### rtl/positional_list_store.sv
// ----------------------------------------------------------------------------
// Positional list store
// Ordered list of signed 32-bit values in a chain of cells, with positional
// insert and delete and a front-to-back read-out.
//
//   channel  dir  payload                     transaction
//   cmd      in   op, position, value         valid && ready
//   rsp      out  element, status, last       valid && ready
//
// Insert and delete shift every cell at once; unused ops hold the cells.
// A read-out first enters the read state, then gives one response beat per
// stored element (a single empty beat if the list is empty); the list rotates
// through cell 0 and is back in order after the last element.
// No command is taken during a read-out or while the response register is
// full and stalled. Reset clears the length; cell contents are not reset.
// ----------------------------------------------------------------------------
`include "positional_list_store_defines.svh"

module positional_list_store (
  input logic      clk,
  input logic      rst,
  pls_cmd_if.sink  cmd,
  pls_rsp_if.source rsp
);
  import pls_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t             state;
  logic [LEN_W-1:0]   length;
  logic [LEN_W-1:0]   length_next;
  logic [IDX_W-1:0]   count;
  logic               out_valid;
  logic signed [31:0] out_element;
  status_t            out_status;
  logic               out_last;

  ctrl_t              ctrl;
  status_t            status;
  logic               start_read;
  logic               accept;
  logic               out_free;
  logic               read_load;
  logic               read_last;
  logic               full;
  logic               empty;
  logic               ins_pos_ok;
  logic               del_pos_ok;
  logic [CMP_W-1:0]   pos_ext;
  logic [CMP_W-1:0]   len_ext;
  logic [IDX_W-1:0]   last_idx;
  logic [IDX_W-1:0]   pos_idx;
  logic signed [31:0] cell_data [CAPACITY];

  assign out_free  = !out_valid || rsp.ready;
  assign cmd.ready = (state == S_IDLE) && out_free;
  assign accept    = cmd.valid && cmd.ready;
  assign read_load = (state == S_READ) && out_free;

  assign full       = (length == LEN_W'(CAPACITY));
  assign empty      = (length == '0);
  assign pos_ext    = CMP_W'(cmd.position);
  assign len_ext    = CMP_W'(length);
  assign ins_pos_ok = (pos_ext >= CMP_W'(1)) && (pos_ext <= len_ext + CMP_W'(1));
  assign del_pos_ok = (pos_ext >= CMP_W'(1)) && (pos_ext <= len_ext);
  assign last_idx   = IDX_W'(length - LEN_W'(1));
  assign pos_idx    = IDX_W'(cmd.position - 7'd1);
  assign read_last  = (count == last_idx);

  // Decode the command into a status and a cell control word
  always_comb begin
    status        = ST_OK;
    start_read    = 1'b0;
    length_next   = length;
    ctrl.mode     = MODE_HOLD;
    ctrl.point    = '0;
    ctrl.last_idx = last_idx;
    ctrl.value    = cmd.value;
    if (read_load) begin
      ctrl.mode = MODE_ROTATE;
    end else if (accept) begin
      unique case (op_t'(cmd.op))
        OP_READOUT: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            start_read = 1'b1;
          end
        end
        OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
          if (full) begin
            status = ST_FULL;
          end else if (op_t'(cmd.op) == OP_INS_FRONT) begin
            ctrl.mode = MODE_INSERT;
          end else if (op_t'(cmd.op) == OP_INS_BACK) begin
            ctrl.mode  = MODE_INSERT;
            ctrl.point = IDX_W'(length);
          end else if (ins_pos_ok) begin
            ctrl.mode  = MODE_INSERT;
            ctrl.point = pos_idx;
          end else begin
            status = ST_RANGE;
          end
          if (ctrl.mode == MODE_INSERT) begin
            length_next = length + LEN_W'(1);
          end
        end
        OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
          if (empty) begin
            status = ST_EMPTY;
          end else if (op_t'(cmd.op) == OP_DEL_FRONT) begin
            ctrl.mode = MODE_DELETE;
          end else if (op_t'(cmd.op) == OP_DEL_BACK) begin
            ctrl.mode  = MODE_DELETE;
            ctrl.point = last_idx;
          end else if (del_pos_ok) begin
            ctrl.mode  = MODE_DELETE;
            ctrl.point = pos_idx;
          end else begin
            status = ST_RANGE;
          end
          if (ctrl.mode == MODE_DELETE) begin
            length_next = length - LEN_W'(1);
          end
        end
        default: status = ST_OK;
      endcase
    end
  end

  // Hold state, length, read counter and the response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      length    <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      length <= length_next;
      if (read_load) begin
        out_valid   <= 1'b1;
        out_element <= cell_data[0];
        out_status  <= ST_OK;
        out_last    <= read_last;
        count       <= count + IDX_W'(1);
        if (read_last) begin
          state <= S_IDLE;
        end
      end else if (accept && start_read) begin
        state <= S_READ;
        count <= '0;
        if (rsp.ready) begin
          out_valid <= 1'b0;
        end
      end else if (accept) begin
        out_valid   <= 1'b1;
        out_element <= '0;
        out_status  <= status;
        out_last    <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.element = out_element;
  assign rsp.status  = out_status;
  assign rsp.last    = out_last;

  // Chain of cells; cell 0 is the list front
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] left_data;
    logic signed [31:0] right_data;
    if (i == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_inner_l
      assign left_data = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right_data = cell_data[i];
    end else begin : g_inner_r
      assign right_data = cell_data[i+1];
    end
    pls_cell u_cell (
      .clk        (clk),
      .idx        (IDX_W'(i)),
      .ctrl       (ctrl),
      .left_data  (left_data),
      .right_data (right_data),
      .front_data (cell_data[0]),
      .data       (cell_data[i])
    );
  end

  `PLS_ASSERT(no_cmd_in_read, state == S_READ, !cmd.ready)
  `PLS_ASSERT(length_bounded, 1'b1, length <= LEN_W'(CAPACITY))
  `PLS_ASSERT_NEXT(single_rsp_after_cmd, accept && (op_t'(cmd.op) != OP_READOUT), out_valid && out_last)
  `PLS_ASSERT_NEXT(read_ends_idle, read_load && read_last, state == S_IDLE)
  `PLS_ASSERT_NEXT(read_keeps_length, state == S_READ, $stable(length))

endmodule

### bench/tb_positional_list_store.sv
// ----------------------------------------------------------------------------
// Positional list store testbench
// Drives list operations into the command channel and checks every response
// against a queue-based copy of the list. A short directed sequence covers
// the empty and out-of-range answers. Random phases then grow the list
// toward capacity and drain it again. Both channels stall at random, apart
// from one quiet stretch.
// ----------------------------------------------------------------------------
module tb_positional_list_store;
  import pls_pkg::*;

  // One expected response beat
  typedef struct {
    logic signed [31:0] element;
    logic [1:0]         status;
    logic               last;
  } list_answer_t;

  // Keeps a copy of the list and the answers still owed by the block
  class list_scoreboard;
    logic signed [31:0] cells[$];
    list_answer_t       owed[$];
    int                 mismatches;
    int                 commands;
    int                 answers;
    int                 full_hits;
    int                 peak_len;

    function new();
      mismatches = 0;
      commands   = 0;
      answers    = 0;
      full_hits  = 0;
      peak_len   = 0;
    endfunction

    function void owe(logic signed [31:0] element, logic [1:0] status, logic last);
      list_answer_t a;
      a.element = element;
      a.status  = status;
      a.last    = last;
      owed.push_back(a);
    endfunction

    // Apply one accepted command to the list copy and queue its answers
    function void note_command(logic [2:0] op, logic [6:0] pos, logic signed [31:0] val);
      int         len;
      logic [1:0] st;
      len = cells.size();
      st  = ST_OK;
      commands++;
      case (op)
        OP_READOUT: begin
          if (len == 0) begin
            owe(32'sd0, ST_EMPTY, 1'b1);
          end else begin
            for (int i = 0; i < len; i++) owe(cells[i], ST_OK, i == len - 1);
          end
          return;
        end
        OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
          if (len >= CAPACITY) begin
            st = ST_FULL;
            full_hits++;
          end else if (op == OP_INS_FRONT) begin
            cells.push_front(val);
          end else if (op == OP_INS_BACK) begin
            cells.push_back(val);
          end else if (pos >= 1 && pos <= len + 1) begin
            cells.insert(pos - 1, val);
          end else begin
            st = ST_RANGE;
          end
        end
        OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
          if (len == 0) begin
            st = ST_EMPTY;
          end else if (op == OP_DEL_FRONT) begin
            cells.delete(0);
          end else if (op == OP_DEL_BACK) begin
            cells.delete(len - 1);
          end else if (pos >= 1 && pos <= len) begin
            cells.delete(pos - 1);
          end else begin
            st = ST_RANGE;
          end
        end
        default: ;
      endcase
      if (cells.size() > peak_len) peak_len = cells.size();
      owe(32'sd0, st, 1'b1);
    endfunction

    // Compare one response beat with the oldest owed answer
    function void check_result(logic signed [31:0] element, logic [1:0] status, logic last);
      list_answer_t a;
      answers++;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response: element %0d status %0d last %0b",
                   element, status, last);
        return;
      end
      a = owed.pop_front();
      if (element !== a.element || status !== a.status || last !== a.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("response %0d: expected element %0d status %0d last %0b, got %0d %0d %0b",
                   answers, a.element, a.status, a.last, element, status, last);
      end
    endfunction
  endclass

  localparam int IDLE_PCT     = 21;
  localparam int RANDOM_ITEMS = 420;
  localparam int LIMIT_CYCLES = 1500000;

  logic clk;
  logic rst;
  bit   quiet;

  pls_cmd_if cmd_ch();
  pls_rsp_if rsp_ch();

  list_scoreboard sb;

  positional_list_store uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit take_break();
    return !quiet && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // Drive the response ready, stalling at random
  always @(negedge clk) begin
    rsp_ch.ready = !take_break();
  end

  // Check every response transaction
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_result(rsp_ch.element, rsp_ch.status, rsp_ch.last);
  end

  // Present one command and hold it until the block takes it
  task automatic send_command(input logic [2:0] op, input logic [6:0] pos,
                              input logic signed [31:0] val);
    @(negedge clk);
    while (take_break()) begin
      cmd_ch.valid = 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid    = 1'b1;
    cmd_ch.op       = op;
    cmd_ch.position = pos;
    cmd_ch.value    = val;
    do @(posedge clk); while (!cmd_ch.ready);
    sb.note_command(op, pos, val);
  endtask

  // Build one random command; phase 0 mixes, 1 grows toward capacity, 2 drains
  task automatic send_random(input int phase);
    int                 r;
    int                 len;
    int                 ins_w;
    logic [2:0]         op;
    logic [6:0]         pos;
    logic signed [31:0] val;
    len   = sb.cells.size();
    ins_w = (phase == 1) ? 75 : (phase == 2) ? 15 : 46;
    r     = $urandom_range(99);
    if (r < 7) op = OP_READOUT;
    else if (r < 9) op = 3'd7;
    else if (r < 9 + ins_w) op = 3'(OP_INS_FRONT + $urandom_range(2));
    else op = 3'(OP_DEL_FRONT + $urandom_range(2));
    // Mostly legal positions, some anywhere in the field
    if ($urandom_range(9) == 0) pos = 7'($urandom_range(127));
    else if (op == OP_INS_AT) pos = 7'($urandom_range(len + 1, 1));
    else if (len > 0) pos = 7'($urandom_range(len, 1));
    else pos = 7'($urandom_range(65, 1));
    case ($urandom_range(15))
      0: val = 32'sh8000_0000;
      1: val = 32'sh7fff_ffff;
      2: val = -32'sd1;
      default: val = $urandom;
    endcase
    send_command(op, pos, val);
  endtask

  initial begin
    sb              = new();
    quiet           = 1'b0;
    rst             = 1'b1;
    cmd_ch.valid    = 1'b0;
    cmd_ch.op       = OP_READOUT;
    cmd_ch.position = '0;
    cmd_ch.value    = '0;
    rsp_ch.ready    = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty list answers, then position bounds on a short list
    send_command(OP_READOUT,   7'd0,   32'sd0);
    send_command(OP_DEL_FRONT, 7'd0,   32'sd0);
    send_command(OP_DEL_BACK,  7'd0,   32'sd0);
    send_command(OP_DEL_AT,    7'd0,   32'sd0);
    send_command(OP_INS_AT,    7'd0,   32'sd11);
    send_command(OP_INS_AT,    7'd2,   32'sd12);
    send_command(OP_INS_AT,    7'd1,   32'sd13);
    send_command(OP_INS_AT,    7'd2,   32'sd14);
    send_command(OP_INS_FRONT, 7'd127, 32'sh8000_0000);
    send_command(OP_INS_BACK,  7'd64,  32'sh7fff_ffff);
    send_command(OP_INS_BACK,  7'd0,   -32'sd1);
    send_command(OP_INS_AT,    7'd3,   32'sd0);
    send_command(OP_READOUT,   7'd0,   32'sd0);
    send_command(OP_DEL_AT,    7'd0,   32'sd0);
    send_command(OP_DEL_AT,    7'd7,   32'sd0);
    send_command(OP_INS_AT,    7'd127, 32'sd15);
    send_command(OP_INS_AT,    7'd65,  32'sd16);
    send_command(3'd7,         7'd1,   32'sd17);
    send_command(OP_DEL_AT,    7'd6,   32'sd0);
    send_command(OP_DEL_FRONT, 7'd0,   32'sd0);
    send_command(OP_DEL_BACK,  7'd0,   32'sd0);
    send_command(OP_DEL_AT,    7'd2,   32'sd0);
    send_command(OP_READOUT,   7'd0,   32'sd0);

    // Random phases, with one stretch of no stalls on either side
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i >= 160 && i < 260);
      send_random((i < 120) ? 0 : (i < 280) ? 1 : 2);
    end
    quiet = 1'b0;
    @(negedge clk);
    cmd_ch.valid = 1'b0;

    // Drain, then watch for stray responses
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("%0d commands, %0d responses checked, peak length %0d, %0d inserts refused full",
             sb.commands, sb.answers, sb.peak_len, sb.full_hits);
    $display("%0d mismatches", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb_positional_list_store OK");
    end else begin
      $display("tb_positional_list_store NOT OK");
    end
    $finish;
  end

  // Give up after a generous fixed time
  initial begin
    #(LIMIT_CYCLES * 8);
    $display("timeout with %0d responses outstanding", sb.owed.size());
    $display("tb_positional_list_store NOT OK");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/pls_pkg.sv
rtl/pls_if.sv
rtl/pls_cell.sv
rtl/positional_list_store.sv
bench/tb_positional_list_store.sv
